// ===== hdl/assert_macros.svh =====
// Assertion macros used by the engine core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/r2fft_pkg.sv =====
`default_nettype none
package r2fft_pkg;
    localparam int MAX_LOG2_POINTS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int TWIDDLE_BITS_DEF    = 16;
    localparam int DATA_BITS           = 32;
    localparam int CFG_IDX_BITS        = 1;
    localparam int CFG_DATA_BITS       = 4;
    localparam int LOG2_BITS           = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LOG2_POINTS  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INVERSE_MODE = 1'b1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh000000007fffffff) r = SAT_MAX;
        else if (v < -64'sh0000000080000000) r = SAT_MIN;
        else r = v[31:0];
        return r;
    endfunction

    // Restoring long division, used only while the twiddle table is built.
    function automatic longint unsigned div_small(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q, r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'd1);
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Taylor-series sine/cosine in Q2.30, computed at elaboration time only.
    function automatic void sin_cos_q30(input longint unsigned x,
                                        output longint s, output longint c);
        longint unsigned x2, ts, tc;
        longint ss, cc;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        ss = longint'(x);
        cc = longint'(64'd1 << 30);
        for (int k = 1; k <= 12; k++) begin
            ts = div_small((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            tc = div_small((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) == 1) begin
                ss = ss - longint'(ts);
                cc = cc - longint'(tc);
            end else begin
                ss = ss + longint'(ts);
                cc = cc + longint'(tc);
            end
        end
        s = ss;
        c = cc;
    endfunction

    function automatic longint to_twiddle(input longint v, input int tw_bits);
        longint top, r;
        int sh;
        sh  = 31 - tw_bits;
        top = (longint'(1) << (tw_bits - 1)) - 1;
        r   = (v < 0) ? 0 : v;
        r   = (r + (longint'(1) << (sh - 1))) >>> sh;
        return (r > top) ? top : r;
    endfunction

    // One twiddle entry: {real, imag} as two signed 32-bit halves.
    function automatic logic [63:0] twiddle_entry(input int i, input int max_log2,
                                                  input int tw_bits);
        longint unsigned r4, quad, rem, ang;
        longint s, c, sq, cq;
        logic [31:0] re, im;
        r4   = longint'(i) * 4;
        quad = r4 >> max_log2;
        rem  = r4 & ((longint'(1) << max_log2) - 1);
        ang  = (64'd26986075410 * rem) >> (max_log2 + 4);
        sin_cos_q30(ang, s, c);
        sq = to_twiddle(s, tw_bits);
        cq = to_twiddle(c, tw_bits);
        if (quad == 0) begin
            re = 32'(cq);
            im = 32'(-sq);
        end else begin
            re = 32'(-sq);
            im = 32'(-cq);
        end
        return {re, im};
    endfunction
endpackage
`default_nettype wire

// ===== hdl/r2fft_ram.sv =====
`default_nettype none
module r2fft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/r2fft_bfly.sv =====
`default_nettype none
// Shared butterfly unit: three registered stages (multiply, combine/round, sum/difference).
module r2fft_bfly #(
    parameter int TWIDDLE_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic signed [31:0] ar,
    input  wire logic signed [31:0] ai,
    input  wire logic signed [31:0] br,
    input  wire logic signed [31:0] bi,
    input  wire logic signed [31:0] cr,
    input  wire logic signed [31:0] ci,
    output logic signed [31:0]      xr,
    output logic signed [31:0]      xi,
    output logic signed [31:0]      yr,
    output logic signed [31:0]      yi
);
    import r2fft_pkg::*;

    localparam int SH = TWIDDLE_BITS - 1;

    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [31:0] a1r_reg, a1i_reg, a2r_reg, a2i_reg;
    logic signed [31:0] pr_reg, pi_reg;
    logic signed [63:0] sum_r, sum_i;
    logic signed [32:0] s_re, s_im, d_re, d_im;

    // Adding the half and shifting arithmetically is floor((v + half) / 2^SH).
    assign sum_r = (p_rr_reg - p_ii_reg + (64'sd1 <<< (SH - 1))) >>> SH;
    assign sum_i = (p_ri_reg + p_ir_reg + (64'sd1 <<< (SH - 1))) >>> SH;
    assign s_re  = 33'(a2r_reg) + 33'(pr_reg);
    assign s_im  = 33'(a2i_reg) + 33'(pi_reg);
    assign d_re  = 33'(a2r_reg) - 33'(pr_reg);
    assign d_im  = 33'(a2i_reg) - 33'(pi_reg);

    always_ff @(posedge aclk) begin
        p_rr_reg <= 64'(br) * 64'(cr);
        p_ii_reg <= 64'(bi) * 64'(ci);
        p_ri_reg <= 64'(br) * 64'(ci);
        p_ir_reg <= 64'(bi) * 64'(cr);
        a1r_reg  <= ar;
        a1i_reg  <= ai;
        pr_reg   <= sat32(sum_r);
        pi_reg   <= sat32(sum_i);
        a2r_reg  <= a1r_reg;
        a2i_reg  <= a1i_reg;
        xr <= sat32(64'(s_re));
        xi <= sat32(64'(s_im));
        yr <= sat32(64'(d_re));
        yi <= sat32(64'(d_im));
    end
endmodule
`default_nettype wire

// ===== hdl/radix2_fft_engine_core.sv =====
// Channel  | Handshake                    | Words carried
// s_ input | s_valid / s_ready            | s_action, s_sample_real, s_sample_imag
// m_ out   | m_valid / m_ready            | m_result_real/imag, m_result_last, m_read_status
// Cfg      | cfg_we (no wait)             | cfg_index, cfg_data
// A load word is written when accepted; a read word goes through a memory read, then output.
// The last load of a frame starts the transform: butterflies run one at a time through the
// shared butterfly unit and single sample memory, each written back before another starts;
// inverse mode adds a scaling pass over all N words, then a closing state. s_ready is low meanwhile.
// Reset is synchronous, active low; the sample memory is not cleared.
// A result word waits in the output register while m_ready is low, and s_ready stays low.
`default_nettype none
`include "assert_macros.svh"
module radix2_fft_engine_core #(
    parameter int MAX_LOG2_POINTS = r2fft_pkg::MAX_LOG2_POINTS_DEF,
    parameter int SAMPLE_BITS     = r2fft_pkg::SAMPLE_BITS_DEF,
    parameter int TWIDDLE_BITS    = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [r2fft_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [r2fft_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_action,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_sample_real,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_sample_imag,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [31:0]                       m_result_real,
    output logic signed [31:0]                       m_result_imag,
    output logic                                     m_result_last,
    output logic                                     m_read_status
);
    import r2fft_pkg::*;

    localparam int AW     = MAX_LOG2_POINTS;
    localparam int NPTS   = 1 << AW;
    localparam int TWD    = (NPTS / 2 > 0) ? NPTS / 2 : 1;
    localparam int TWA    = (TWD > 1) ? $clog2(TWD) : 1;
    localparam int QD     = (TWD > 1) ? TWD / 2 : 1;
    localparam int QA     = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW     = AW + 1;

    typedef enum logic [3:0] {
        ST_LOAD, ST_RD_WAIT, ST_RD_OUT,
        ST_BF_RA, ST_BF_RB, ST_BF_WAIT, ST_BF_CAP, ST_BF_RUN, ST_BF_WA, ST_BF_WB,
        ST_SC_RD, ST_SC_WAIT, ST_SC_WR, ST_DONE
    } state_t;

    state_t state_reg;
    logic [LOG2_BITS-1:0] log2_cfg_reg;
    logic                 inverse_reg;
    logic [CW-1:0]        load_count_reg, read_count_reg;
    logic                 ready_phase_reg;
    logic [LOG2_BITS-1:0] stage_reg;
    logic [AW-1:0]        base_reg, j_reg, idx_reg;
    logic [2:0]           wait_reg;
    logic signed [31:0]   ar_reg, ai_reg, br_reg, bi_reg;
    logic [TWA-1:0]       tw_idx_reg;

    logic [LOG2_BITS-1:0] nb;
    logic [CW-1:0]        npts;
    logic [AW-1:0]        half, a_addr, b_addr, rev_addr;
    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [63:0]          wdata, rdata;
    logic signed [31:0]   cr, ci, xr, xi, yr, yi;
    logic [63:0]          tw_word;
    logic [QA-1:0]        tw_q_idx;
    logic                 tw_quad;
    logic signed [31:0]   tw_im;
    logic signed [63:0]   sc_r, sc_i;

    // Quarter table: the second quarter reuses it with cosine and sine swapped.
    logic [63:0] tw_rom [QD];
    for (genvar g = 0; g < QD; g++) begin : g_tw
        assign tw_rom[g] = twiddle_entry(g, MAX_LOG2_POINTS, TWIDDLE_BITS);
    end

    always_comb begin
        if (log2_cfg_reg < LOG2_BITS'(1)) nb = LOG2_BITS'(1);
        else if (32'(log2_cfg_reg) > MAX_LOG2_POINTS) nb = LOG2_BITS'(MAX_LOG2_POINTS);
        else nb = log2_cfg_reg;
    end
    assign npts   = CW'(1) << nb;
    assign half   = AW'(CW'(1) << (stage_reg - LOG2_BITS'(1)));
    assign a_addr = base_reg + j_reg;
    assign b_addr = a_addr + half;

    always_comb begin
        logic [AW-1:0] v;
        v = load_count_reg[AW-1:0];
        rev_addr = '0;
        for (int k = 0; k < AW; k++) begin
            if (k < 32'(nb)) rev_addr[32'(nb) - 1 - k] = v[k];
        end
    end

    // Stride 2^(MAX-stage) folded in as the tap index advances.
    assign tw_q_idx = (QD > 1) ? tw_idx_reg[QA-1:0] : '0;
    assign tw_quad  = (TWD > 1) ? tw_idx_reg[TWA-1] : 1'b0;
    assign tw_word  = tw_rom[tw_q_idx];
    assign cr       = tw_quad ? tw_word[31:0] : tw_word[63:32];
    assign tw_im    = tw_quad ? -tw_word[63:32] : tw_word[31:0];
    assign ci       = inverse_reg ? -tw_im : tw_im;

    r2fft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
        .aclk(aclk), .ar(ar_reg), .ai(ai_reg), .br(br_reg), .bi(bi_reg),
        .cr(cr), .ci(ci), .xr(xr), .xi(xi), .yr(yr), .yi(yi)
    );

    assign sc_r = (64'(ar_reg) + ((64'sd1 <<< nb) >>> 1)) >>> nb;
    assign sc_i = (64'(ai_reg) + ((64'sd1 <<< nb) >>> 1)) >>> nb;

    always_comb begin
        we    = 1'b0;
        waddr = rev_addr;
        wdata = {32'(s_sample_real), 32'(s_sample_imag)};
        raddr = a_addr;
        case (state_reg)
            ST_LOAD: begin
                we = s_valid && s_ready && s_action == ACT_LOAD;
                raddr = read_count_reg[AW-1:0];
            end
            ST_RD_WAIT: raddr = read_count_reg[AW-1:0];
            ST_BF_RB:  raddr = b_addr;
            ST_BF_WA: begin
                we = 1'b1; waddr = a_addr; wdata = {xr, xi};
            end
            ST_BF_WB: begin
                we = 1'b1; waddr = b_addr; wdata = {yr, yi};
            end
            ST_SC_RD: raddr = idx_reg;
            ST_SC_WR: begin
                we = 1'b1; waddr = idx_reg; wdata = {sat32(sc_r), sat32(sc_i)};
            end
            default: ;
        endcase
    end

    r2fft_ram #(.WIDTH(64), .DEPTH(NPTS)) u_store (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign s_ready = (state_reg == ST_LOAD) && !m_valid && !cfg_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            log2_cfg_reg    <= LOG2_BITS'(10);
            inverse_reg     <= 1'b0;
            load_count_reg  <= '0;
            read_count_reg  <= '0;
            ready_phase_reg <= 1'b0;
            m_valid         <= 1'b0;
            stage_reg       <= '0;
            base_reg        <= '0;
            j_reg           <= '0;
            idx_reg         <= '0;
            wait_reg        <= '0;
            tw_idx_reg      <= '0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cfg_we) begin
                if (cfg_index == CFG_LOG2_POINTS) log2_cfg_reg <= cfg_data;
                else inverse_reg <= cfg_data[0];
                load_count_reg  <= '0;
                read_count_reg  <= '0;
                ready_phase_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (s_valid && s_ready && !cfg_we) begin
                        if (s_action == ACT_LOAD) begin
                            ready_phase_reg <= 1'b0;
                            read_count_reg  <= '0;
                            if (ready_phase_reg) begin
                                load_count_reg <= CW'(1);
                            end else if (load_count_reg + CW'(1) >= npts) begin
                                load_count_reg <= '0;
                                stage_reg <= LOG2_BITS'(1);
                                base_reg <= '0;
                                j_reg <= '0;
                                tw_idx_reg <= '0;
                                state_reg <= ST_BF_RA;
                            end else begin
                                load_count_reg <= load_count_reg + CW'(1);
                            end
                        end else if (!ready_phase_reg) begin
                            m_valid <= 1'b1;
                            m_result_real <= '0;
                            m_result_imag <= '0;
                            m_result_last <= 1'b0;
                            m_read_status <= 1'b1;
                        end else begin
                            state_reg <= ST_RD_WAIT;
                        end
                    end
                end
                ST_RD_WAIT: state_reg <= ST_RD_OUT;
                ST_RD_OUT: begin
                    m_valid       <= 1'b1;
                    m_result_real <= rdata[63:32];
                    m_result_imag <= rdata[31:0];
                    m_read_status <= 1'b0;
                    m_result_last <= (read_count_reg == npts - CW'(1));
                    if (read_count_reg == npts - CW'(1)) begin
                        read_count_reg  <= '0;
                        ready_phase_reg <= 1'b0;
                    end else begin
                        read_count_reg <= read_count_reg + CW'(1);
                    end
                    state_reg <= ST_LOAD;
                end
                ST_BF_RA: state_reg <= ST_BF_RB;
                ST_BF_RB: state_reg <= ST_BF_WAIT;
                // The lower leg arrives first; the upper leg is read again meanwhile.
                ST_BF_WAIT: begin
                    br_reg <= rdata[63:32];
                    bi_reg <= rdata[31:0];
                    state_reg <= ST_BF_CAP;
                end
                ST_BF_CAP: begin
                    ar_reg <= rdata[63:32];
                    ai_reg <= rdata[31:0];
                    wait_reg <= 3'd2;
                    state_reg <= ST_BF_RUN;
                end
                ST_BF_RUN: begin
                    if (wait_reg == 3'd0) state_reg <= ST_BF_WA;
                    else wait_reg <= wait_reg - 3'd1;
                end
                ST_BF_WA: state_reg <= ST_BF_WB;
                ST_BF_WB: begin
                    if (32'(j_reg) + 1 < 32'(half)) begin
                        j_reg <= j_reg + AW'(1);
                        tw_idx_reg <= tw_idx_reg +
                            TWA'(32'(1) << (MAX_LOG2_POINTS - 32'(stage_reg)));
                        state_reg <= ST_BF_RA;
                    end else if (32'(base_reg) + 2 * 32'(half) < 32'(npts)) begin
                        base_reg <= AW'(32'(base_reg) + 2 * 32'(half));
                        j_reg <= '0;
                        tw_idx_reg <= '0;
                        state_reg <= ST_BF_RA;
                    end else if (stage_reg < nb) begin
                        stage_reg <= stage_reg + LOG2_BITS'(1);
                        base_reg <= '0;
                        j_reg <= '0;
                        tw_idx_reg <= '0;
                        state_reg <= ST_BF_RA;
                    end else if (inverse_reg) begin
                        idx_reg <= '0;
                        state_reg <= ST_SC_RD;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SC_RD: state_reg <= ST_SC_WAIT;
                ST_SC_WAIT: begin
                    ar_reg <= rdata[63:32];
                    ai_reg <= rdata[31:0];
                    state_reg <= ST_SC_WR;
                end
                ST_SC_WR: begin
                    if (32'(idx_reg) + 1 < 32'(npts)) begin
                        idx_reg <= idx_reg + AW'(1);
                        state_reg <= ST_SC_RD;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    ready_phase_reg <= 1'b1;
                    read_count_reg  <= '0;
                    state_reg <= ST_LOAD;
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    `ASSERT_IMPLY(a_ready_only_idle, aclk, aresetn, s_ready, state_reg == ST_LOAD,
        "ready outside idle state")
    `ASSERT_IMPLY(a_last_valid, aclk, aresetn, m_valid && m_result_last, !m_read_status,
        "last marker on a status word")
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid,
        "result word dropped while stalled")
endmodule
`default_nettype wire

// ===== test/radix2_fft_engine_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module radix2_fft_engine_core_tb;
    import r2fft_pkg::*;

    localparam int MAX_L2  = 10;
    localparam int MAX_PTS = 1 << MAX_L2;
    localparam int ROM_LEN = MAX_PTS / 2;
    localparam int CYCLE_LIMIT = 900000;
    localparam int RANDOM_WORDS = 120;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               last;
        logic               status;
    } fft_bin_t;

    class fft_scoreboard;
        logic [3:0]         size_reg;
        logic               inverse_reg;
        int unsigned        load_cnt;
        int unsigned        read_cnt;
        bit                 bins_ready;
        longint             mem_re[MAX_PTS];
        longint             mem_im[MAX_PTS];
        longint             rom_re[ROM_LEN];
        longint             rom_im[ROM_LEN];
        fft_bin_t           bins_q[$];
        int                 errors;
        int                 checked;
        int                 frames;

        function new();
            build_rom();
            size_reg    = 4'd10;
            inverse_reg = 1'b0;
            restart();
            errors  = 0;
            checked = 0;
            frames  = 0;
        endfunction

        function void restart();
            load_cnt   = 0;
            read_cnt   = 0;
            bins_ready = 0;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint round_shift(longint v, int s);
            if (s == 0) return v;
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        // Quarter-wave cosine and negative sine in Q1.15 from a Q2.30 series.
        function longint to_q15(longint v);
            longint r;
            r = (v < 0) ? 0 : v;
            r = (r + (longint'(1) << 14)) >>> 15;
            return (r > 32767) ? 32767 : r;
        endfunction

        function void build_rom();
            longint unsigned x, x2, ts, tc, r4, rem;
            longint ss, cc, sq, cq;
            for (int i = 0; i < ROM_LEN; i++) begin
                r4  = longint'(i) * 4;
                rem = r4 & (MAX_PTS - 1);
                x   = (64'd26986075410 * rem) >> (MAX_L2 + 4);
                x2  = (x * x) >> 30;
                ts  = x;
                tc  = 64'd1 << 30;
                ss  = longint'(x);
                cc  = longint'(64'd1 << 30);
                for (int k = 1; k <= 12; k++) begin
                    ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                    tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                    if (k % 2 == 1) begin
                        ss = ss - longint'(ts);
                        cc = cc - longint'(tc);
                    end else begin
                        ss = ss + longint'(ts);
                        cc = cc + longint'(tc);
                    end
                end
                sq = to_q15(ss);
                cq = to_q15(cc);
                if ((r4 >> MAX_L2) == 0) begin
                    rom_re[i] = cq;
                    rom_im[i] = -sq;
                end else begin
                    rom_re[i] = -sq;
                    rom_im[i] = -cq;
                end
            end
        endfunction

        function int active_log2();
            if (size_reg < 1) return 1;
            if (size_reg > MAX_L2) return MAX_L2;
            return size_reg;
        endfunction

        function void write_reg(logic idx, logic [3:0] data);
            if (idx == CFG_LOG2_POINTS) size_reg = data;
            else inverse_reg = data[0];
            restart();
        endfunction

        function void transform();
            int nb, n, half, stride, t, a, b;
            longint cr, ci, br, bi, ar, ai, pr, pi;
            nb = active_log2();
            n  = 1 << nb;
            for (int st = 1; st <= nb; st++) begin
                half   = 1 << (st - 1);
                stride = 1 << (MAX_L2 - st);
                for (int base = 0; base < n; base += 2 * half) begin
                    for (int j = 0; j < half; j++) begin
                        t  = (j * stride) & (ROM_LEN - 1);
                        a  = base + j;
                        b  = a + half;
                        cr = rom_re[t];
                        ci = inverse_reg ? -rom_im[t] : rom_im[t];
                        br = mem_re[b];
                        bi = mem_im[b];
                        ar = mem_re[a];
                        ai = mem_im[a];
                        pr = clip32(round_shift(br * cr - bi * ci, 15));
                        pi = clip32(round_shift(br * ci + bi * cr, 15));
                        mem_re[a] = clip32(ar + pr);
                        mem_im[a] = clip32(ai + pi);
                        mem_re[b] = clip32(ar - pr);
                        mem_im[b] = clip32(ai - pi);
                    end
                end
            end
            if (inverse_reg) begin
                for (int i = 0; i < n; i++) begin
                    mem_re[i] = clip32(round_shift(mem_re[i], nb));
                    mem_im[i] = clip32(round_shift(mem_im[i], nb));
                end
            end
        endfunction

        function void note_word(logic act, logic signed [15:0] re, logic signed [15:0] im);
            int nb, n, addr, idx;
            fft_bin_t b;
            nb = active_log2();
            n  = 1 << nb;
            if (act == ACT_LOAD) begin
                if (bins_ready) restart();
                addr = 0;
                idx  = load_cnt & (n - 1);
                for (int k = 0; k < nb; k++) addr = (addr << 1) | ((idx >> k) & 1);
                mem_re[addr] = re;
                mem_im[addr] = im;
                load_cnt++;
                if (load_cnt >= n) begin
                    transform();
                    load_cnt   = 0;
                    read_cnt   = 0;
                    bins_ready = 1;
                    frames++;
                end
            end else if (!bins_ready) begin
                b = '{re: 0, im: 0, last: 1'b0, status: 1'b1};
                bins_q.push_back(b);
            end else begin
                idx = read_cnt & (n - 1);
                b = '{re: mem_re[idx][31:0], im: mem_im[idx][31:0],
                      last: (idx == n - 1), status: 1'b0};
                bins_q.push_back(b);
                read_cnt++;
                if (b.last) restart();
            end
        endfunction

        function void check_result(fft_bin_t got);
            fft_bin_t exp_bin;
            if (bins_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word re=%0d im=%0d", $time, got.re, got.im);
                return;
            end
            exp_bin = bins_q.pop_front();
            checked++;
            if (got.re !== exp_bin.re) begin
                errors++;
                $display("%0t: result_real expected %0d actual %0d", $time, exp_bin.re, got.re);
            end
            if (got.im !== exp_bin.im) begin
                errors++;
                $display("%0t: result_imag expected %0d actual %0d", $time, exp_bin.im, got.im);
            end
            if (got.last !== exp_bin.last) begin
                errors++;
                $display("%0t: result_last expected %0b actual %0b", $time,
                         exp_bin.last, got.last);
            end
            if (got.status !== exp_bin.status) begin
                errors++;
                $display("%0t: read_status expected %0b actual %0b", $time,
                         exp_bin.status, got.status);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic                cfg_index;
    logic [3:0]          cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_action;
    logic signed [15:0]  s_sample_real;
    logic signed [15:0]  s_sample_imag;
    logic                m_valid;
    logic                m_ready;
    logic signed [31:0]  m_result_real;
    logic signed [31:0]  m_result_imag;
    logic                m_result_last;
    logic                m_read_status;

    fft_scoreboard       sb;
    int                  cycles;
    int                  words_sent;
    int                  rx_hold;
    bit                  calm;

    radix2_fft_engine_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_sample_real(s_sample_real), .s_sample_imag(s_sample_imag),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_real(m_result_real), .m_result_imag(m_result_imag),
        .m_result_last(m_result_last), .m_read_status(m_read_status)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(logic act, logic signed [15:0] re, logic signed [15:0] im);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_action      = act;
        s_sample_real = re;
        s_sample_imag = im;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(act, re, im);
        words_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.bins_q.size() != 0) @(negedge aclk);
    endtask

    // A read word cannot finish before a running transform does, so its result
    // marks the engine idle.
    task automatic write_reg(logic idx, logic [3:0] data);
        send_word(ACT_READ, 16'sd0, 16'sd0);
        wait_drain();
        repeat (20) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    function automatic logic signed [15:0] pick_sample(int style);
        case (style)
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, 400) - 200;
            default: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    // One frame: loads with occasional stray reads, then some, all or more than all bins, and an optional load.
    task automatic run_frame(int n, int reads, bit reload);
        int style;
        bit real_only;
        style     = $urandom_range(0, 5) == 0 ? 2 : $urandom_range(0, 1);
        real_only = $urandom_range(0, 3) == 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) send_word(ACT_READ, pick_sample(0), pick_sample(0));
            send_word(ACT_LOAD, pick_sample(style), real_only ? 16'sd0 : pick_sample(style));
        end
        for (int i = 0; i < reads; i++) send_word(ACT_READ, pick_sample(0), pick_sample(0));
        if (reload) send_word(ACT_LOAD, pick_sample(0), pick_sample(0));
    endtask

    initial begin
        fft_bin_t got;
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = calm ? 0 : $urandom_range(0, 14);
            if (rx_hold > 0) begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{re: m_result_real, im: m_result_imag,
                    last: m_result_last, status: m_read_status};
            sb.check_result(got);
        end
    end

    initial begin
        int l2, n, start;
        sb            = new();
        cycles        = 0;
        words_sent    = 0;
        rx_hold       = 0;
        calm          = 0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_LOG2_POINTS;
        cfg_data      = 4'd0;
        s_valid       = 1'b0;
        s_action      = ACT_LOAD;
        s_sample_real = 16'sd0;
        s_sample_imag = 16'sd0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: read before any transform, then two-point frames at the extremes.
        send_word(ACT_READ, 16'sd0, 16'sd0);
        write_reg(CFG_LOG2_POINTS, 4'd1);
        send_word(ACT_LOAD, 16'sh7fff, 16'sh8000);
        send_word(ACT_LOAD, 16'sh8000, 16'sh7fff);
        send_word(ACT_READ, 16'sd0, 16'sd0);
        send_word(ACT_READ, 16'sd0, 16'sd0);
        send_word(ACT_READ, 16'sd0, 16'sd0);
        send_word(ACT_LOAD, -16'sd1, 16'sd0);
        send_word(ACT_LOAD, 16'sd0, -16'sd1);
        send_word(ACT_READ, 16'sd0, 16'sd0);
        send_word(ACT_LOAD, 16'sd5, 16'sd3);      // drops the bin still pending
        send_word(ACT_LOAD, 16'sh7fff, 16'sh7fff);
        send_word(ACT_READ, 16'sd0, 16'sd0);
        write_reg(CFG_INVERSE_MODE, 4'hf);
        write_reg(CFG_LOG2_POINTS, 4'd0);          // size zero behaves as two points
        send_word(ACT_LOAD, 16'sh8000, 16'sh8000);
        send_word(ACT_LOAD, 16'sh8000, 16'sh8000);
        send_word(ACT_READ, 16'sd0, 16'sd0);
        send_word(ACT_READ, 16'sd0, 16'sd0);
        write_reg(CFG_INVERSE_MODE, 4'h0);
        // One large frame exercises the deep stages and every even-indexed twiddle entry.
        write_reg(CFG_LOG2_POINTS, 4'd9);
        calm = 1;
        run_frame(1 << 9, 20, 0);
        calm = 0;

        // Back-pressure: the output stalls while reads keep coming.
        write_reg(CFG_LOG2_POINTS, 4'd4);
        run_frame(16, 0, 0);
        rx_hold = 300;
        for (int i = 0; i < 16; i++) send_word(ACT_READ, 16'sd0, 16'sd0);
        wait_drain();

        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            calm = $urandom_range(0, 3) == 0;
            l2 = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 5);
            write_reg(CFG_LOG2_POINTS, l2[3:0]);
            write_reg(CFG_INVERSE_MODE, 4'($urandom_range(0, 15)));
            n = 1 << sb.active_log2();
            if (n > 64) n = 8;                      // keep big sizes rare and short
            if (n == 8 && sb.active_log2() > 6) begin
                write_reg(CFG_LOG2_POINTS, 4'd3);
            end
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: run_frame(n, $urandom_range(0, n - 1), 1);
                    1: run_frame(n, n + $urandom_range(0, 2), 0);
                    default: run_frame(n, n, 0);
                endcase
            end
        end

        wait_drain();
        repeat (50) @(negedge aclk);
        $display("Ran %0d input words over %0d transforms; %0d result words checked.",
                 words_sent, sb.frames, sb.checked);
        $display("Sizes 2 to 512, forward and inverse, with stray reads and dropped frames.");
        if (sb.errors == 0 && sb.bins_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.errors, sb.bins_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== radix2_fft_engine_core.f =====
+incdir+hdl
hdl/r2fft_pkg.sv
hdl/r2fft_ram.sv
hdl/r2fft_bfly.sv
hdl/radix2_fft_engine_core.sv
test/radix2_fft_engine_core_tb.sv
